>>> hdl/chbd_pkg.sv
package chbd_pkg;

    localparam int MAX_LENGTH   = 16;
    localparam int SYMBOL_DEPTH = 256;

    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int FIRST_W = 17;
    localparam int BASE_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 8;

    localparam int CNT_AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int SYM_AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;

    localparam logic [FIRST_W-1:0] FIRST_SAT = {FIRST_W{1'b1}};
    localparam logic [BASE_W-1:0]  BASE_SAT  = {BASE_W{1'b1}};

    localparam logic [1:0] MODE_COUNT  = 2'd0;
    localparam logic [1:0] MODE_SYMBOL = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    typedef struct packed {
        logic found;
        logic error;
    } walk_flags_t;

    typedef struct packed {
        logic              we;
        logic [SYM_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [SYM_AW-1:0] raddr;
    } sym_port_t;

endpackage

>>> hdl/chbd_ram.sv
module chbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/chbd_walk.sv
module chbd_walk import chbd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [1:0]        mode,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] load_value,
    input  logic              bit_req,
    output walk_flags_t       flags,
    output sym_port_t         sym
);

    logic [CODE_W-1:0]  code_bits_reg,   code_bits_next;
    logic [LEN_W-1:0]   code_length_reg, code_length_next;
    logic [FIRST_W-1:0] first_code_reg,  first_code_next;
    logic [BASE_W-1:0]  symbol_base_reg, symbol_base_next;
    logic               fwd_reg,         fwd_next;
    logic [BYTE_W-1:0]  fwd_data_reg;

    logic               cnt_we;
    logic [CNT_AW-1:0]  cnt_raddr;
    logic [BYTE_W-1:0]  cnt_rdata;
    logic [BYTE_W-1:0]  cnt;

    logic [CODE_W-1:0]  nbits;
    logic [LEN_W-1:0]   nlen;
    logic [FIRST_W:0]   diff_wide;
    logic [CODE_W-1:0]  diff;
    logic               in_range;
    logic [FIRST_W-1:0] idx;
    logic               idx_ok;
    logic [FIRST_W:0]   fc_sum;
    logic [FIRST_W+1:0] fc_shift;
    logic [BASE_W:0]    sb_sum;

    // count for the next bit is prefetched at the length the walk will hold
    chbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LENGTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (position[CNT_AW-1:0]),
        .wdata (load_value),
        .re    (1'b1),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign cnt       = fwd_reg ? fwd_data_reg : cnt_rdata;
    assign nbits     = {code_bits_reg[CODE_W-2:0], bit_req};
    assign nlen      = code_length_reg + LEN_W'(1);
    assign diff_wide = {2'b00, nbits} - {1'b0, first_code_reg};
    assign diff      = diff_wide[CODE_W-1:0];
    assign in_range  = !diff_wide[FIRST_W] && ({8'd0, diff[CODE_W-1:0]} < {16'd0, cnt});
    assign idx       = FIRST_W'(symbol_base_reg) + FIRST_W'(diff);
    assign idx_ok    = idx < FIRST_W'(SYMBOL_DEPTH);
    assign fc_sum    = {1'b0, first_code_reg} + (FIRST_W+1)'(cnt);
    assign fc_shift  = {fc_sum, 1'b0};
    assign sb_sum    = {1'b0, symbol_base_reg} + (BASE_W+1)'(cnt);
    assign cnt_raddr = code_length_next[CNT_AW-1:0];

    always_comb
    begin
        code_bits_next   = code_bits_reg;
        code_length_next = code_length_reg;
        first_code_next  = first_code_reg;
        symbol_base_next = symbol_base_reg;
        cnt_we           = 1'b0;
        flags            = '0;
        sym              = '0;
        sym.waddr        = position[SYM_AW-1:0];
        sym.wdata        = load_value;
        sym.raddr        = idx[SYM_AW-1:0];
        if (take)
        begin
            unique case (mode)
                MODE_COUNT:
                begin
                    cnt_we           = 9'(position) < 9'(MAX_LENGTH);
                    code_bits_next   = '0;
                    code_length_next = '0;
                    first_code_next  = '0;
                    symbol_base_next = '0;
                end
                MODE_SYMBOL:
                begin
                    sym.we           = 9'(position) < 9'(SYMBOL_DEPTH);
                    code_bits_next   = '0;
                    code_length_next = '0;
                    first_code_next  = '0;
                    symbol_base_next = '0;
                end
                MODE_DECODE:
                begin
                    code_bits_next   = '0;
                    code_length_next = '0;
                    first_code_next  = '0;
                    symbol_base_next = '0;
                    if (nlen == '0 || nlen > LEN_W'(MAX_LENGTH))
                    begin
                        flags.error = 1'b1;
                    end
                    else if (in_range)
                    begin
                        flags.found = idx_ok;
                        flags.error = !idx_ok;
                        sym.re      = idx_ok;
                    end
                    else if (nlen >= LEN_W'(MAX_LENGTH))
                    begin
                        flags.error = 1'b1;
                    end
                    else
                    begin
                        code_bits_next   = nbits;
                        code_length_next = nlen;
                        first_code_next  = (fc_shift > (FIRST_W+2)'(FIRST_SAT)) ?
                                           FIRST_SAT : fc_shift[FIRST_W-1:0];
                        symbol_base_next = sb_sum[BASE_W] ? BASE_SAT : sb_sum[BASE_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // forward a count written to the slot being prefetched
    assign fwd_next = cnt_we && (position[CNT_AW-1:0] == cnt_raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg   <= '0;
            code_length_reg <= '0;
            first_code_reg  <= '0;
            symbol_base_reg <= '0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            code_bits_reg   <= code_bits_next;
            code_length_reg <= code_length_next;
            first_code_reg  <= first_code_next;
            symbol_base_reg <= symbol_base_next;
            fwd_reg         <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_next)
        begin
            fwd_data_reg <= load_value;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        code_length_reg < LEN_W'(MAX_LENGTH))
        else $error("walk length reached the limit without restart");

    a_root_clean: assert property (@(posedge clk) disable iff (!rst_n)
        code_length_reg == '0 |->
            code_bits_reg == '0 && first_code_reg == '0 && symbol_base_reg == '0)
        else $error("walk at root with stale code state");

endmodule

>>> hdl/canonical_huffman_bit_decoder_unit.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_ready   mode, position, load_value, bit_req
// out      output     out_valid/out_ready found, symbol, error
//
// One item per cycle sustained while out_ready keeps the output moving; a result passes
// through the s2 register and then the output register before out_valid rises.
// The per-bit loop is one count RAM read plus one compare; the count for the
// next length is prefetched so the loop does not wait on the count RAM read.
// Symbol lookup goes through the symbol RAM's registered read.
// Reset clears the walk to the root; the count and symbol tables are not cleared.
// A stalled output holds the result; in_ready drops only when both stages are full
// and out_ready is low.
module canonical_huffman_bit_decoder_unit import chbd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] load_value,
    input  logic              bit_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [BYTE_W-1:0] symbol,
    output logic              error
);

    logic              take;
    logic              s2_move;
    walk_flags_t       flags;
    sym_port_t         sym;
    logic [BYTE_W-1:0] sym_rdata;

    logic              s2_valid_reg, s2_valid_next;
    walk_flags_t       s2_flags_reg;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [BYTE_W-1:0] symbol_reg;
    logic              error_reg;

    assign s2_move  = !out_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s2_move;
    assign take     = in_valid && in_ready;

    chbd_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .mode       (mode),
        .position   (position),
        .load_value (load_value),
        .bit_req    (bit_req),
        .flags      (flags),
        .sym        (sym)
    );

    chbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SYMBOL_DEPTH)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (sym.we),
        .waddr (sym.waddr),
        .wdata (sym.wdata),
        .re    (sym.re),
        .raddr (sym.raddr),
        .rdata (sym_rdata)
    );

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (take)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
        out_valid_next = s2_move ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_flags_reg <= flags;
        end
        // symbol RAM data holds while stalled: reads are issued only on transfer
        if (s2_move && s2_valid_reg)
        begin
            found_reg  <= s2_flags_reg.found;
            symbol_reg <= s2_flags_reg.found ? sym_rdata : '0;
            error_reg  <= s2_flags_reg.error;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign symbol    = symbol_reg;
    assign error     = error_reg;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && error))
        else $error("found and error both set");

    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> symbol == '0)
        else $error("symbol not cleared without a match");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s2_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

endmodule

>>> tb/tb_canonical_huffman_bit_decoder_unit.sv
module tb_canonical_huffman_bit_decoder_unit;
    import chbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         RANDOM_ITEMS = 1850;

    typedef struct packed {
        logic              found;
        logic [BYTE_W-1:0] symbol;
        logic              error;
    } decode_t;

    class huffman_walk;
        logic [BYTE_W-1:0]  counts [MAX_LENGTH];
        logic [BYTE_W-1:0]  symbols [SYMBOL_DEPTH];
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic [FIRST_W-1:0] first;
        logic [BASE_W-1:0]  base;
        decode_t            pending [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            code  = '0;
            len   = '0;
            first = '0;
            base  = '0;
        endfunction

        function void take_item(input logic [1:0] m, input logic [POS_W-1:0] pos,
                                input logic [BYTE_W-1:0] val, input logic b);
            decode_t r;
            int      cnt;
            int      diff;
            int      idx;
            int      grown;
            r = '0;
            case (m)
                MODE_COUNT:
                begin
                    if (pos < MAX_LENGTH)
                        counts[CNT_AW'(pos)] = val;
                    restart();
                end
                MODE_SYMBOL:
                begin
                    if (pos < SYMBOL_DEPTH)
                        symbols[pos] = val;
                    restart();
                end
                MODE_DECODE:
                begin
                    code = {code[CODE_W-2:0], b};
                    len  = len + 1'b1;
                    if (len == 0 || len > MAX_LENGTH)
                    begin
                        restart();
                        r.error = 1'b1;
                    end
                    else
                    begin
                        cnt  = int'(counts[CNT_AW'(len - 1'b1)]);
                        diff = int'(code) - int'(first);
                        if (diff >= 0 && diff < cnt)
                        begin
                            idx = int'(base) + diff;
                            restart();
                            if (idx < SYMBOL_DEPTH)
                            begin
                                r.found  = 1'b1;
                                r.symbol = symbols[SYM_AW'(idx)];
                            end
                            else
                                r.error = 1'b1;
                        end
                        else if (len >= MAX_LENGTH)
                        begin
                            restart();
                            r.error = 1'b1;
                        end
                        else
                        begin
                            // saturate rather than wrap on oversubscribed counts
                            grown = (int'(first) + cnt) * 2;
                            first = (grown > int'(FIRST_SAT)) ? FIRST_SAT : grown[FIRST_W-1:0];
                            grown = int'(base) + cnt;
                            base  = (grown > int'(BASE_SAT)) ? BASE_SAT : grown[BASE_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
            pending = {pending, r};
        endfunction

        function void compare_decoded(input logic f, input logic [BYTE_W-1:0] s,
                                      input logic e);
            decode_t got;
            decode_t want;
            got = {f, s, e};
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transfer found=%0b symbol=%02h error=%0b",
                         $time, f, s, e);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display({"%0t: expected found=%0b symbol=%02h error=%0b, ",
                          "actual found=%0b symbol=%02h error=%0b"},
                         $time, want.found, want.symbol, want.error, f, s, e);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [1:0]        mode       = MODE_COUNT;
    logic [POS_W-1:0]  position   = '0;
    logic [BYTE_W-1:0] load_value = '0;
    logic              bit_req    = 1'b0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              found;
    logic [BYTE_W-1:0] symbol;
    logic              error;

    huffman_walk board;
    int          code_counts [MAX_LENGTH];
    int          items_sent   = 0;
    int unsigned cycle_count  = 0;
    bit          send_calm    = 1'b0;
    bit          take_calm    = 1'b0;

    canonical_huffman_bit_decoder_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .position   (position),
        .load_value (load_value),
        .bit_req    (bit_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .symbol     (symbol),
        .error      (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int least(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    task automatic send_item(input logic [1:0] m, input logic [POS_W-1:0] pos,
                             input logic [BYTE_W-1:0] val, input logic b);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        position   <= pos;
        load_value <= val;
        bit_req    <= b;
        do @(posedge clk); while (!in_ready);
        board.take_item(m, pos, val, b);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic load_counts();
        int i;
        for (i = 0; i < MAX_LENGTH; i++)
            send_item(MODE_COUNT, POS_W'(i), BYTE_W'(code_counts[i]), 1'($urandom));
    endtask

    // walk the canonical tables to find the code of symbol index k
    task automatic send_symbol(input int k);
        int first_c;
        int base_c;
        int value;
        int l;
        int i;
        first_c = 0;
        base_c  = 0;
        for (l = 1; l <= MAX_LENGTH; l++)
        begin
            if (k < base_c + code_counts[l-1])
                break;
            first_c = (first_c + code_counts[l-1]) << 1;
            base_c  = base_c + code_counts[l-1];
        end
        if (l > MAX_LENGTH)
            return;
        value = first_c + k - base_c;
        for (i = l - 1; i >= 0; i--)
            send_item(MODE_DECODE, POS_W'($urandom), BYTE_W'($urandom), value[i]);
    endtask

    initial
    begin : drain_results
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = take_calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.compare_decoded(found, symbol, error);
        end
    end

    initial
    begin : stimulus
        int i;
        int r;
        int start_items;
        int style;
        int top;
        int room;
        int table_total;
        bit table_ok;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both tables so that no lookup ever hits an unwritten entry
        for (i = 0; i < MAX_LENGTH; i++)
            code_counts[i] = 0;
        load_counts();
        for (i = 0; i < SYMBOL_DEPTH; i++)
            send_item(MODE_SYMBOL, POS_W'(i), BYTE_W'($urandom), 1'($urandom));

        send_item(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1);
        send_item(MODE_COUNT, POS_W'(MAX_LENGTH), 8'hFF, 1'b0);
        send_item(MODE_COUNT, 8'hFF, 8'hFF, 1'b1);
        send_item(MODE_SYMBOL, 8'h00, 8'h00, 1'b0);
        send_item(MODE_SYMBOL, 8'hFF, 8'hFF, 1'b1);
        // no codes at any length: overrun on the sixteenth bit
        repeat (MAX_LENGTH) send_item(MODE_DECODE, 8'h00, 8'h00, 1'b1);
        send_item(MODE_COUNT, 8'h00, 8'h02, 1'b0);
        code_counts[0] = 2;
        send_symbol(0);
        send_symbol(1);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            take_calm = ($urandom_range(0, 3) == 0);
            style       = $urandom_range(0, 9);
            table_ok    = (style != 6) && (style != 7);
            table_total = 0;
            if (style == 6)
            begin
                // heavy long lengths: base saturates, indices run past the table
                for (i = 0; i < MAX_LENGTH; i++)
                    code_counts[i] = (i >= 8) ? $urandom_range(128, 255) : 0;
            end
            else if (style == 7)
            begin
                for (i = 0; i < MAX_LENGTH; i++)
                    code_counts[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
            end
            else
            begin
                top  = (style == 8) ? $urandom_range(1, 4) : $urandom_range(2, MAX_LENGTH);
                room = 1;
                for (i = 0; i < MAX_LENGTH; i++)
                begin
                    room = room * 2;
                    if (i + 1 > top)
                        code_counts[i] = 0;
                    else if (i + 1 == top)
                    begin
                        code_counts[i] = least(least(room, 255), SYMBOL_DEPTH - table_total);
                        if ($urandom_range(0, 3) == 0)
                            code_counts[i] = $urandom_range(0, code_counts[i]);
                    end
                    else
                        code_counts[i] = $urandom_range(0, least(least(room - 1, 255),
                                                                 SYMBOL_DEPTH - table_total));
                    room        = room - code_counts[i];
                    table_total = table_total + code_counts[i];
                end
            end
            load_counts();
            repeat ($urandom_range(0, 4))
                send_item(MODE_SYMBOL, POS_W'($urandom), BYTE_W'($urandom), 1'($urandom));

            repeat ($urandom_range(10, 40))
            begin
                r = $urandom_range(0, 99);
                if (r < 75 && table_ok && table_total > 0)
                    send_symbol($urandom_range(0, table_total - 1));
                else if (r < 90)
                    repeat ($urandom_range(1, 20))
                        send_item(MODE_DECODE, POS_W'($urandom), BYTE_W'($urandom),
                                  1'($urandom));
                else if (r < 94)
                    send_item(MODE_UNUSED, POS_W'($urandom), BYTE_W'($urandom),
                              1'($urandom));
                else if (r < 97)
                    send_item(MODE_COUNT, POS_W'($urandom_range(MAX_LENGTH, 255)),
                              BYTE_W'($urandom), 1'($urandom));
                else
                    // restart the walk, often mid-code
                    send_item(MODE_SYMBOL, POS_W'($urandom), BYTE_W'($urandom),
                              1'($urandom));
            end
        end

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
